FILE: rtl/dtt_pkg.sv
package dtt_pkg;

  // Field widths fixed by the interface.
  localparam int CMD_W       = 3;
  localparam int INDEX_W     = 4;
  localparam int CODE_W      = 8;
  localparam int DELAY_W     = 32;
  localparam int CAP_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Depth of the command queue between the front and the executor.
  localparam int QUEUE_DEPTH = 2;

  // Command codes as they arrive on the input beat.
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GOTO   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FORCE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELAY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVALID  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CAP_W-1:0]  CAP_RESET     = 5'd16;
  localparam logic [CODE_W-1:0] INVALID_RESET = 8'd255;
  localparam logic [CODE_W-1:0] INIT_RESET    = 8'd0;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd2;

  // Operation class decided by the front.
  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_GOTO   = 3'd1,
    OP_FORCE  = 3'd2,
    OP_DELAY  = 3'd3,
    OP_SCAN   = 3'd4,
    OP_TICK   = 3'd5,
    OP_IGNORE = 3'd6
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] task_index;
    logic [CODE_W-1:0]  state_value;
    logic [DELAY_W-1:0] delay_ms;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  slot;
    logic [CODE_W-1:0]   old_state;
    logic [CODE_W-1:0]   pending_state;
    logic                dispatched;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [CODE_W-1:0] invalid_code;
    logic [CODE_W-1:0] init_code;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] task_index;
    logic [CODE_W-1:0]  state_value;
    logic [DELAY_W-1:0] delay_ms;
  } entry_t;

endpackage

FILE: rtl/dtt_front.sv
module dtt_front (
  input  logic            start,
  input  dtt_pkg::item_t  item,
  input  logic            queue_full,
  output logic            busy,
  output logic            push,
  output dtt_pkg::entry_t entry
);

  // The front takes a beat whenever the queue has room.
  assign busy = queue_full;
  assign push = start && !queue_full;

  // Classify the command; codes with no meaning become a no-op.
  always_comb begin
    entry.task_index  = item.task_index;
    entry.state_value = item.state_value;
    entry.delay_ms    = item.delay_ms;
    case (item.command)
      dtt_pkg::CMD_CREATE: entry.op = dtt_pkg::OP_CREATE;
      dtt_pkg::CMD_GOTO:   entry.op = dtt_pkg::OP_GOTO;
      dtt_pkg::CMD_FORCE:  entry.op = dtt_pkg::OP_FORCE;
      dtt_pkg::CMD_DELAY:  entry.op = dtt_pkg::OP_DELAY;
      dtt_pkg::CMD_SCAN:   entry.op = dtt_pkg::OP_SCAN;
      dtt_pkg::CMD_TICK:   entry.op = dtt_pkg::OP_TICK;
      default:             entry.op = dtt_pkg::OP_IGNORE;
    endcase
  end

endmodule

FILE: rtl/dtt_queue.sv
module dtt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dtt_pkg::entry_t wr_entry,
  input  logic            pop,
  output dtt_pkg::entry_t rd_entry,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = (dtt_pkg::QUEUE_DEPTH > 1) ? $clog2(dtt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(dtt_pkg::QUEUE_DEPTH + 1);

  dtt_pkg::entry_t  slots [dtt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(dtt_pkg::QUEUE_DEPTH));
  assign rd_entry = slots[head];

  // Pointer advance with wrap at the queue depth.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(dtt_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + PTR_W'(1);
  endfunction

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wr_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= advance(tail);
      end
      if (pop) begin
        head <= advance(head);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/dtt_back.sv
module dtt_back #(
  parameter int MAX_TASKS  = 16,
  parameter int STATE_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  dtt_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  dtt_pkg::entry_t  q_entry,
  output logic             pop,
  output logic             done,
  output dtt_pkg::result_t result
);

  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > dtt_pkg::CAP_W) ? CNT_W : dtt_pkg::CAP_W;
  localparam int DW    = dtt_pkg::DELAY_W;

  typedef enum logic [1:0] {
    BS_IDLE = 2'b01,
    BS_SCAN = 2'b10
  } back_state_t;

  back_state_t state, state_next;

  logic [DW-1:0]    time_now, time_now_next;
  logic [CNT_W-1:0] task_count, task_count_next;
  logic [AW-1:0]    scan_idx, scan_idx_next;

  // Per-slot task memories.
  logic [STATE_BITS-1:0] cur_mem   [MAX_TASKS];
  logic [STATE_BITS-1:0] pend_mem  [MAX_TASKS];
  logic [STATE_BITS-1:0] tgt_mem   [MAX_TASKS];
  logic [DW-1:0]         start_mem [MAX_TASKS];
  logic [DW-1:0]         len_mem   [MAX_TASKS];

  logic [STATE_BITS-1:0] rd_cur, rd_pend, rd_tgt;
  logic [DW-1:0]         rd_start, rd_len;

  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  cur_we, pend_we, tgt_we, delay_we;
  logic [STATE_BITS-1:0] cur_wd, pend_wd, tgt_wd;
  logic [DW-1:0]         start_wd, len_wd;

  logic                  res_valid_next;
  dtt_pkg::result_t      res_next;

  logic [STATE_BITS-1:0] inval, init_code, sv;
  logic [CMP_W-1:0]      cap_ext, limit, count_ext, idx_ext;
  logic                  can_create, slot_ok, is_last, delayed, expired;
  logic [DW-1:0]         elapsed;

  // Operand preparation shared by all commands.
  always_comb begin
    inval      = STATE_BITS'(cfg.invalid_code);
    init_code  = STATE_BITS'(cfg.init_code);
    sv         = STATE_BITS'(q_entry.state_value);
    cap_ext    = CMP_W'(cfg.capacity);
    limit      = (cap_ext < CMP_W'(MAX_TASKS)) ? cap_ext : CMP_W'(MAX_TASKS);
    count_ext  = CMP_W'(task_count);
    idx_ext    = CMP_W'(q_entry.task_index);
    can_create = (count_ext < limit);
    slot_ok    = (idx_ext < count_ext);
    is_last    = ((CMP_W'(scan_idx) + CMP_W'(1)) == count_ext);
    delayed    = (rd_tgt != inval);
    elapsed    = time_now - rd_start;
    expired    = (elapsed >= rd_len);
  end

  // Executor: simple commands complete in the idle state, a scan walks one slot a cycle.
  always_comb begin
    state_next      = state;
    time_now_next   = time_now;
    task_count_next = task_count;
    scan_idx_next   = scan_idx;
    pop             = 1'b0;
    rd_addr         = '0;
    wr_addr         = scan_idx;
    cur_we          = 1'b0;
    pend_we         = 1'b0;
    tgt_we          = 1'b0;
    delay_we        = 1'b0;
    cur_wd          = inval;
    pend_wd         = inval;
    tgt_wd          = inval;
    start_wd        = '0;
    len_wd          = '0;
    res_valid_next  = 1'b0;
    res_next        = '0;
    res_next.status = dtt_pkg::STATUS_OK;
    res_next.last   = 1'b1;

    case (state)
      BS_IDLE: begin
        if (!q_empty) begin
          pop            = 1'b1;
          res_valid_next = 1'b1;
          case (q_entry.op)
            dtt_pkg::OP_CREATE: begin
              if (can_create) begin
                wr_addr         = AW'(task_count);
                cur_we          = 1'b1;
                pend_we         = 1'b1;
                tgt_we          = 1'b1;
                delay_we        = 1'b1;
                pend_wd         = init_code;
                task_count_next = task_count + CNT_W'(1);
                res_next.slot   = dtt_pkg::INDEX_W'(task_count);
              end else begin
                res_next.status = dtt_pkg::STATUS_FULL;
              end
            end
            dtt_pkg::OP_GOTO, dtt_pkg::OP_FORCE, dtt_pkg::OP_DELAY: begin
              wr_addr       = AW'(q_entry.task_index);
              res_next.slot = q_entry.task_index;
              if (!slot_ok) begin
                res_next.status = dtt_pkg::STATUS_NO_SLOT;
              end else if (q_entry.op == dtt_pkg::OP_DELAY) begin
                tgt_we   = 1'b1;
                delay_we = 1'b1;
                tgt_wd   = sv;
                start_wd = time_now;
                len_wd   = q_entry.delay_ms;
              end else begin
                pend_we = 1'b1;
                pend_wd = sv;
                if (q_entry.op == dtt_pkg::OP_FORCE) begin
                  tgt_we   = 1'b1;
                  delay_we = 1'b1;
                end
              end
            end
            dtt_pkg::OP_SCAN: begin
              // An empty table gives no result at all.
              res_valid_next = 1'b0;
              if (task_count != '0) begin
                state_next    = BS_SCAN;
                scan_idx_next = '0;
              end
            end
            dtt_pkg::OP_TICK: begin
              time_now_next = time_now + DW'(1);
            end
            default: begin
            end
          endcase
        end
      end

      BS_SCAN: begin
        // Slot scan_idx has its data ready; the next slot is read meanwhile.
        res_valid_next = 1'b1;
        res_next.slot  = dtt_pkg::INDEX_W'(scan_idx);
        res_next.last  = is_last;
        if (!delayed) begin
          pend_we                = 1'b1;
          cur_we                 = (rd_pend != inval);
          cur_wd                 = rd_pend;
          res_next.old_state     = dtt_pkg::CODE_W'(rd_cur);
          res_next.pending_state = dtt_pkg::CODE_W'(rd_pend);
          res_next.dispatched    = 1'b1;
        end else if (expired) begin
          pend_we  = 1'b1;
          pend_wd  = rd_tgt;
          tgt_we   = 1'b1;
          delay_we = 1'b1;
        end
        if (is_last) begin
          state_next = BS_IDLE;
        end else begin
          rd_addr       = scan_idx + AW'(1);
          scan_idx_next = scan_idx + AW'(1);
        end
      end

      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  // Task memories: one write address and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[wr_addr] <= cur_wd;
    end
    if (pend_we) begin
      pend_mem[wr_addr] <= pend_wd;
    end
    if (tgt_we) begin
      tgt_mem[wr_addr] <= tgt_wd;
    end
    if (delay_we) begin
      start_mem[wr_addr] <= start_wd;
      len_mem[wr_addr]   <= len_wd;
    end
    rd_cur   <= cur_mem[rd_addr];
    rd_pend  <= pend_mem[rd_addr];
    rd_tgt   <= tgt_mem[rd_addr];
    rd_start <= start_mem[rd_addr];
    rd_len   <= len_mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BS_IDLE;
      time_now   <= '0;
      task_count <= '0;
      scan_idx   <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      time_now   <= time_now_next;
      task_count <= task_count_next;
      scan_idx   <= scan_idx_next;
      done       <= res_valid_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

FILE: rtl/delayed_transition_task_table.sv
// Channel      Signals                          Handshake
// command in   item (command, task_index, ...)   start, busy: taken when start && !busy
// config in    cfg_index, cfg_data               cfg_write: taken on every edge it is high
// result out   result (slot, old_state, ...)     done: one cycle per beat, no back-pressure
//
// Create, goto, goto_force, delay, tick and unknown commands are executed in the idle
// state; a command that meets an empty queue is written to the queue, popped by the
// executor and its result beat registered. A scan starts the slot memory read, then
// one slot a cycle, set by the single read port of the task memories.
// A two-entry queue sits behind the command port; busy is high while it is full.
// Synchronous reset empties the queue, clears the time and the task count and
// restores the configuration defaults; the task memories need no clearing.
module delayed_transition_task_table #(
  parameter int MAX_TASKS  = 16,
  parameter int STATE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  dtt_pkg::item_t                      item,
  input  logic                                cfg_write,
  input  logic [dtt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dtt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                done,
  output dtt_pkg::result_t                    result
);

  dtt_pkg::cfg_t   cfg;
  dtt_pkg::entry_t push_entry;
  dtt_pkg::entry_t head_entry;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity     <= dtt_pkg::CAP_RESET;
      cfg.invalid_code <= dtt_pkg::INVALID_RESET;
      cfg.init_code    <= dtt_pkg::INIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dtt_pkg::CFG_CAPACITY: cfg.capacity     <= cfg_data[dtt_pkg::CAP_W-1:0];
        dtt_pkg::CFG_INVALID:  cfg.invalid_code <= cfg_data;
        dtt_pkg::CFG_INIT:     cfg.init_code    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dtt_front u_front (
    .start      (start),
    .item       (item),
    .queue_full (q_full),
    .busy       (busy),
    .push       (push),
    .entry      (push_entry)
  );

  dtt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (head_entry),
    .empty    (q_empty),
    .full     (q_full)
  );

  dtt_back #(
    .MAX_TASKS  (MAX_TASKS),
    .STATE_BITS (STATE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_entry (head_entry),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: rtl/dtt_checker.sv
module dtt_checker (
  input logic             clk,
  input logic             rst,
  input logic             busy,
  input logic             done,
  input dtt_pkg::result_t result
);

  // Reset leaves no result beat pending and the command port open.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("result beat or busy after reset");

  // The beats of one scan follow each other without a gap.
  a_scan_unbroken: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done)
    else $error("scan results interrupted");

  // Only a scan gives beats that are not last, and those never fail.
  a_inner_ok: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> result.status == dtt_pkg::STATUS_OK)
    else $error("error status inside a scan");

  // A failed command is a single beat with no dispatch.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    done && result.status != dtt_pkg::STATUS_OK |-> result.last && !result.dispatched)
    else $error("error result is not a lone beat");

  // States are reported only for a dispatched task.
  a_states_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.dispatched |-> result.old_state == '0 && result.pending_state == '0)
    else $error("state codes on a beat without dispatch");

endmodule

bind delayed_transition_task_table dtt_checker u_dtt_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);
